@@ sv/lzgm_pkg.sv @@
// Shared constants, command codes and the token group type of the LZ77 match finder.
package lzgm_pkg;

  localparam int TILE_DEPTH = 4096;
  localparam int DICT_DEPTH = 4096;
  localparam int MIN_MATCH  = 4;
  localparam int MAX_MATCH  = 255;

  localparam int CMD_W    = 2;
  localparam int BYTE_W   = 8;
  localparam int TOKEN_W  = 9;
  localparam int OFFSET_W = 16;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DICT  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TILE  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_PULL  = 2'd3;

  localparam logic [TOKEN_W-1:0] ESCAPE_TOKEN = 9'd256;

  // Outcome of one pull, handed from the search sequencer to the token emitter
  typedef struct packed {
    logic                is_match;
    logic                tile_done;
    logic [BYTE_W-1:0]   length;
    logic [OFFSET_W-1:0] offset;
    logic [BYTE_W-1:0]   literal;
  } group_t;

endpackage

@@ sv/lzgm_if.sv @@
// Valid/ready channel interfaces for command words and token words.
interface lzgm_req_if;
  logic                          valid;
  logic                          ready;
  logic [lzgm_pkg::CMD_W-1:0]    command;
  logic [lzgm_pkg::BYTE_W-1:0]   byte_value;

  modport source (output valid, command, byte_value, input ready);
  modport sink   (input valid, command, byte_value, output ready);
endinterface

interface lzgm_tok_if;
  logic                          valid;
  logic                          ready;
  logic [lzgm_pkg::TOKEN_W-1:0]  token;
  logic                          group_last;
  logic                          tile_last;

  modport source (output valid, token, group_last, tile_last, input ready);
  modport sink   (input valid, token, group_last, tile_last, output ready);
endinterface

@@ sv/lz77_greedy_match_finder.sv @@
// Top level of the LZ77 greedy exhaustive match finder.
//
//   channel   dir  word fields                          completes when
//   request   in   command[1:0], byte_value[7:0]        valid & ready
//   result    out  token[8:0], group_last, tile_last    valid & ready
//
// Load and clear words are taken back to back while the search is idle. A
// pull word runs the search sequencer: every candidate reads each compared
// byte from the registered store, then does the byte compare; the length or
// store bound can end it straight after the read. A pull holds the request
// channel until its group is handed to the emitter; bytes are compared one at
// a time, with one read per store per cycle.
// Reset (rst, synchronous) empties both stores' lengths and the position.
// A full token register stalls only the handover of the next group; loads
// are taken while the last token of a group waits to be read.
module lz77_greedy_match_finder #(
  parameter int TILE_DEPTH = lzgm_pkg::TILE_DEPTH,
  parameter int DICT_DEPTH = lzgm_pkg::DICT_DEPTH,
  parameter int MIN_MATCH  = lzgm_pkg::MIN_MATCH,
  parameter int MAX_MATCH  = lzgm_pkg::MAX_MATCH
) (
  input  logic        clk,
  input  logic        rst,
  lzgm_req_if.sink    request,
  lzgm_tok_if.source  result
);

  // Search outcome travelling to the emitter
  lzgm_pkg::group_t grp;
  logic             grp_valid;
  logic             grp_ready;

  // Search: owns the stores, their fill counts and the encode position
  lzgm_search #(
    .TILE_DEPTH (TILE_DEPTH),
    .DICT_DEPTH (DICT_DEPTH),
    .MIN_MATCH  (MIN_MATCH),
    .MAX_MATCH  (MAX_MATCH)
  ) u_search (
    .clk       (clk),
    .rst       (rst),
    .request   (request),
    .grp       (grp),
    .grp_valid (grp_valid),
    .grp_ready (grp_ready)
  );

  // Emitter: one word per cycle whenever the output register is free
  lzgm_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .grp       (grp),
    .grp_valid (grp_valid),
    .grp_ready (grp_ready),
    .result    (result)
  );

endmodule

@@ sv/lzgm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lzgm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/lzgm_search.sv @@
// Store loading and greedy match search sequencer around the tile and dictionary byte compares.
module lzgm_search #(
  parameter int TILE_DEPTH = lzgm_pkg::TILE_DEPTH,
  parameter int DICT_DEPTH = lzgm_pkg::DICT_DEPTH,
  parameter int MIN_MATCH  = lzgm_pkg::MIN_MATCH,
  parameter int MAX_MATCH  = lzgm_pkg::MAX_MATCH
) (
  input  logic             clk,
  input  logic             rst,
  lzgm_req_if.sink         request,
  output lzgm_pkg::group_t grp,
  output logic             grp_valid,
  input  logic             grp_ready
);

  localparam int BW = lzgm_pkg::BYTE_W;
  localparam int OW = lzgm_pkg::OFFSET_W;
  localparam int PW = $clog2(TILE_DEPTH + 1);
  localparam int DW = $clog2(DICT_DEPTH + 1);
  localparam int TA = $clog2(TILE_DEPTH);
  localparam int DA = $clog2(DICT_DEPTH);
  localparam int CW = (PW > DW) ? PW : DW;
  localparam int SW = ((CW > BW) ? CW : BW) + 1;
  localparam int WW = (SW > OW) ? SW : OW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TRD  = 3'd1;
  localparam logic [2:0] S_TCMP = 3'd2;
  localparam logic [2:0] S_DRD  = 3'd3;
  localparam logic [2:0] S_DCMP = 3'd4;
  localparam logic [2:0] S_LIT  = 3'd5;
  localparam logic [2:0] S_HAND = 3'd6;

  logic [2:0]    state;
  logic [PW-1:0] pos;
  logic [PW-1:0] tlen;
  logic [DW-1:0] dlen;
  logic [CW-1:0] cand;
  logic [BW-1:0] len;
  logic [BW-1:0] best_len;
  logic [OW-1:0] best_off;

  logic [SW-1:0] pos_sum;
  logic [SW-1:0] cand_sum;
  logic [SW-1:0] cand_inc;
  logic [SW-1:0] adv;
  logic          tile_ok;
  logic          dict_ok;
  logic          accept;
  logic          tile_we;
  logic          dict_we;
  logic          hit;
  logic          is_match;
  logic [OW-1:0] tile_off;
  logic [OW-1:0] dict_off;
  logic [BW-1:0] tile_a_q;
  logic [BW-1:0] tile_b_q;
  logic [BW-1:0] dict_q;

  assign pos_sum  = SW'(pos) + SW'(len);
  assign cand_sum = SW'(cand) + SW'(len);
  assign cand_inc = SW'(cand) + SW'(1);
  assign tile_ok  = (pos_sum < SW'(tlen)) && (len < BW'(MAX_MATCH));
  assign dict_ok  = tile_ok && (cand_sum < SW'(dlen));
  assign hit      = len > best_len;
  assign tile_off = OW'(WW'(pos) - WW'(cand));
  assign dict_off = OW'(WW'(tlen) - WW'(cand));
  assign is_match = best_len >= BW'(MIN_MATCH);
  assign adv      = is_match ? (SW'(pos) + SW'(best_len)) : (SW'(pos) + SW'(1));

  assign accept  = request.valid && request.ready;
  assign tile_we = accept && (request.command == lzgm_pkg::CMD_TILE) &&
                   (tlen < PW'(TILE_DEPTH));
  assign dict_we = accept && (request.command == lzgm_pkg::CMD_DICT) &&
                   (dlen < DW'(DICT_DEPTH));

  assign request.ready = (state == S_IDLE);
  assign grp_valid     = (state == S_HAND);

  always_comb begin
    grp.is_match  = is_match;
    grp.tile_done = adv >= SW'(tlen);
    grp.length    = best_len;
    grp.offset    = best_off;
    grp.literal   = tile_b_q;
  end

  // Two copies of the tile store give the candidate and current reads in the same cycle
  lzgm_ram #(.WIDTH(BW), .DEPTH(TILE_DEPTH)) u_tile_a (
    .clk   (clk),
    .we    (tile_we),
    .waddr (tlen[TA-1:0]),
    .wdata (request.byte_value),
    .raddr (cand_sum[TA-1:0]),
    .rdata (tile_a_q)
  );

  lzgm_ram #(.WIDTH(BW), .DEPTH(TILE_DEPTH)) u_tile_b (
    .clk   (clk),
    .we    (tile_we),
    .waddr (tlen[TA-1:0]),
    .wdata (request.byte_value),
    .raddr (pos_sum[TA-1:0]),
    .rdata (tile_b_q)
  );

  lzgm_ram #(.WIDTH(BW), .DEPTH(DICT_DEPTH)) u_dict (
    .clk   (clk),
    .we    (dict_we),
    .waddr (dlen[DA-1:0]),
    .wdata (request.byte_value),
    .raddr (cand_sum[DA-1:0]),
    .rdata (dict_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pos   <= '0;
      tlen  <= '0;
      dlen  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (request.command)
              lzgm_pkg::CMD_CLEAR: begin
                pos  <= '0;
                tlen <= '0;
                dlen <= '0;
              end
              lzgm_pkg::CMD_DICT: begin
                if (dict_we) begin
                  dlen <= dlen + DW'(1);
                end
              end
              lzgm_pkg::CMD_TILE: begin
                if (tile_we) begin
                  tlen <= tlen + PW'(1);
                end
              end
              lzgm_pkg::CMD_PULL: begin
                // nothing to do once the tile is finished
                if (pos < tlen) begin
                  cand     <= '0;
                  len      <= '0;
                  best_len <= '0;
                  best_off <= '0;
                  if (pos != '0) begin
                    state <= S_TRD;
                  end else if (dlen != '0) begin
                    state <= S_DRD;
                  end else begin
                    state <= S_LIT;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_TRD, S_TCMP: begin
          if ((state == S_TRD) && tile_ok) begin
            state <= S_TCMP;
          end else if ((state == S_TCMP) && (tile_a_q == tile_b_q)) begin
            len   <= len + BW'(1);
            state <= S_TRD;
          end else begin
            // candidate finished: keep it if strictly longer, advance
            if (hit) begin
              best_len <= len;
              best_off <= tile_off;
            end
            len <= '0;
            if (cand_inc < SW'(pos)) begin
              cand  <= CW'(cand_inc);
              state <= S_TRD;
            end else begin
              cand  <= '0;
              state <= (dlen != '0) ? S_DRD : S_LIT;
            end
          end
        end
        S_DRD, S_DCMP: begin
          if ((state == S_DRD) && dict_ok) begin
            state <= S_DCMP;
          end else if ((state == S_DCMP) && (dict_q == tile_b_q)) begin
            len   <= len + BW'(1);
            state <= S_DRD;
          end else begin
            if (hit) begin
              best_len <= len;
              best_off <= dict_off;
            end
            len <= '0;
            if (cand_inc < SW'(dlen)) begin
              cand  <= CW'(cand_inc);
              state <= S_DRD;
            end else begin
              state <= S_LIT;
            end
          end
        end
        S_LIT: begin
          // len is zero here, so the current-side read fetches the literal
          state <= S_HAND;
        end
        S_HAND: begin
          if (grp_ready) begin
            pos   <= PW'(adv);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ sv/lzgm_emit.sv @@
// Token emitter: serialises one literal or match group into the output register.
module lzgm_emit (
  input  logic             clk,
  input  logic             rst,
  input  lzgm_pkg::group_t grp,
  input  logic             grp_valid,
  output logic             grp_ready,
  lzgm_tok_if.source       result
);

  localparam logic [1:0] T_ESC  = 2'd0;
  localparam logic [1:0] T_OFFH = 2'd1;
  localparam logic [1:0] T_OFFL = 2'd2;
  localparam logic [1:0] T_LEN  = 2'd3;

  localparam int TW = lzgm_pkg::TOKEN_W;
  localparam int BW = lzgm_pkg::BYTE_W;

  lzgm_pkg::group_t g;
  logic             busy;
  logic [1:0]       cnt;
  logic             vld;
  logic [TW-1:0]    tok;
  logic             gl;
  logic             tl;
  logic             slot;
  logic             last;
  logic [TW-1:0]    tok_next;

  assign grp_ready         = !busy;
  assign slot              = !vld || result.ready;
  assign last              = !g.is_match || (cnt == T_LEN);
  assign result.valid      = vld;
  assign result.token      = tok;
  assign result.group_last = gl;
  assign result.tile_last  = tl;

  always_comb begin
    if (!g.is_match) begin
      tok_next = TW'(g.literal);
    end else begin
      unique case (cnt)
        T_ESC:   tok_next = lzgm_pkg::ESCAPE_TOKEN;
        T_OFFH:  tok_next = TW'(g.offset[2*BW-1:BW]);
        T_OFFL:  tok_next = TW'(g.offset[BW-1:0]);
        T_LEN:   tok_next = TW'(g.length);
        default: tok_next = lzgm_pkg::ESCAPE_TOKEN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      vld  <= 1'b0;
    end else begin
      if (grp_valid && !busy) begin
        busy <= 1'b1;
        cnt  <= T_ESC;
        g    <= grp;
      end
      if (busy && slot) begin
        vld <= 1'b1;
        tok <= tok_next;
        gl  <= last;
        tl  <= last && g.tile_done;
        cnt <= cnt + 2'd1;
        if (last) begin
          busy <= 1'b0;
        end
      end else if (result.ready) begin
        vld <= 1'b0;
      end
    end
  end

endmodule
